// ===== src/wald_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wald_pkg
// Shared types, constants and the square root step for the waypoint
// arc-length decimator.
// ----------------------------------------------------------------------------
package wald_pkg;

    localparam int COORD_W    = 24;   // Q15.8 position
    localparam int FIELD_W    = 16;   // pass-through fields
    localparam int SPACING_W  = 24;
    localparam int TRAVEL_W   = 26;
    localparam int HALF_W     = 12;   // half of an absolute difference
    localparam int SQ_W       = 48;   // one squared difference
    localparam int RAD_W      = 52;   // radicand, padded to whole digit pairs
    localparam int REM_W      = 28;
    localparam int ROOT_W     = 26;
    localparam int ROOT_STEPS = 13;   // two root bits per cycle
    localparam int STEP_CNT_W = 4;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 24'd1280;  // 5.0 m

    typedef struct packed {
        logic                      start_of_path;
        logic signed [COORD_W-1:0] x_position;
        logic signed [COORD_W-1:0] y_position;
        logic signed [FIELD_W-1:0] heading;
        logic signed [FIELD_W-1:0] speed;
        logic signed [FIELD_W-1:0] acceleration;
        logic signed [FIELD_W-1:0] speed_command;
        logic signed [FIELD_W-1:0] steer_command;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] kept_x;
        logic signed [COORD_W-1:0] kept_y;
        logic signed [FIELD_W-1:0] kept_heading;
        logic signed [FIELD_W-1:0] kept_speed;
        logic signed [FIELD_W-1:0] kept_acceleration;
        logic signed [FIELD_W-1:0] kept_speed_command;
        logic signed [FIELD_W-1:0] kept_steer_command;
    } out_item_t;

    // One classified point waiting for the distance unit
    typedef struct packed {
        logic               seed;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        out_item_t          item;
    } queue_entry_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_state_t;

    // One restoring digit step of the integer square root
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t cur, input logic [1:0] pair);
        sqrt_state_t      nxt;
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        shifted = {cur.rem[REM_W-3:0], pair};
        trial   = {cur.root, 2'b01};
        if (shifted >= trial) begin
            nxt.rem  = shifted - trial;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = shifted;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

// ===== src/wald_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wald_front
// Accepts points, tracks the previous position and classifies each point
// as a path seed or a step; pushes absolute coordinate differences.
// ----------------------------------------------------------------------------
module wald_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  wald_pkg::in_item_t      s_item,
    output logic                    push_valid,
    input  logic                    push_ready,
    output wald_pkg::queue_entry_t  push_data
);

    logic [wald_pkg::COORD_W-1:0] prev_x_reg, prev_x_next;
    logic [wald_pkg::COORD_W-1:0] prev_y_reg, prev_y_next;
    logic                         have_prev_reg, have_prev_next;

    logic                         accept;
    logic [wald_pkg::COORD_W:0]   dx, dy, neg_dx, neg_dy;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    always_comb begin
        dx     = {s_item.x_position[wald_pkg::COORD_W-1], s_item.x_position}
               - {prev_x_reg[wald_pkg::COORD_W-1], prev_x_reg};
        dy     = {s_item.y_position[wald_pkg::COORD_W-1], s_item.y_position}
               - {prev_y_reg[wald_pkg::COORD_W-1], prev_y_reg};
        neg_dx = -dx;
        neg_dy = -dy;

        push_data.seed = s_item.start_of_path || !have_prev_reg;
        push_data.ax   = dx[wald_pkg::COORD_W] ? neg_dx[wald_pkg::COORD_W-1:0]
                                               : dx[wald_pkg::COORD_W-1:0];
        push_data.ay   = dy[wald_pkg::COORD_W] ? neg_dy[wald_pkg::COORD_W-1:0]
                                               : dy[wald_pkg::COORD_W-1:0];
        push_data.item.kept_x             = s_item.x_position;
        push_data.item.kept_y             = s_item.y_position;
        push_data.item.kept_heading       = s_item.heading;
        push_data.item.kept_speed         = s_item.speed;
        push_data.item.kept_acceleration  = s_item.acceleration;
        push_data.item.kept_speed_command = s_item.speed_command;
        push_data.item.kept_steer_command = s_item.steer_command;

        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        if (accept) begin
            prev_x_next    = s_item.x_position;
            prev_y_next    = s_item.y_position;
            have_prev_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else begin
            have_prev_reg <= have_prev_next;
        end
    end

    // position itself is only meaningful once have_prev is set
    always_ff @(posedge aclk) begin
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
    end

endmodule

// ===== src/wald_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wald_queue
// Small circular queue of classified points between front and back.
// ----------------------------------------------------------------------------
module wald_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  wald_pkg::queue_entry_t  push_data,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output wald_pkg::queue_entry_t  pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wald_pkg::queue_entry_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/wald_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wald_back
// Emits kept points, computes the step length with split squares and an
// iterative square root, and keeps the travelled-distance accumulator.
// ----------------------------------------------------------------------------
module wald_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [wald_pkg::SPACING_W-1:0]  spacing,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  wald_pkg::queue_entry_t          pop_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output wald_pkg::out_item_t             m_item
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SQUARE = 6'b000010,
        ST_SUM    = 6'b000100,
        ST_LOAD   = 6'b001000,
        ST_ROOT   = 6'b010000,
        ST_ACCUM  = 6'b100000
    } back_state_t;

    localparam int HW  = wald_pkg::HALF_W;
    localparam int PW  = 2 * wald_pkg::HALF_W;
    localparam int SQW = wald_pkg::SQ_W;
    localparam int TW  = wald_pkg::TRAVEL_W;
    localparam logic [wald_pkg::STEP_CNT_W-1:0] LAST_STEP =
        wald_pkg::STEP_CNT_W'(wald_pkg::ROOT_STEPS - 1);

    back_state_t state_reg, state_next;

    logic [TW-1:0]                   travelled_reg, travelled_next;
    logic                            out_valid_reg, out_valid_next;
    wald_pkg::out_item_t             out_item_reg, out_item_next;

    logic [wald_pkg::COORD_W-1:0]    ax_reg, ax_next, ay_reg, ay_next;
    logic [PW-1:0]                   xhh_reg, xhl_reg, xll_reg, yhh_reg, yhl_reg, yll_reg;
    logic [PW-1:0]                   xhh_next, xhl_next, xll_next, yhh_next, yhl_next, yll_next;
    logic [SQW-1:0]                  sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [wald_pkg::RAD_W-1:0]      rad_reg, rad_next;
    wald_pkg::sqrt_state_t           sq_reg, sq_next, sq_mid;
    logic [wald_pkg::STEP_CNT_W-1:0] step_reg, step_next;

    logic                            out_free, do_pop, emit;
    logic [TW:0]                     sum;
    logic [TW-1:0]                   sat;

    assign out_free  = !out_valid_reg || m_ready;
    assign pop_ready = (state_reg == ST_IDLE)
                    && (pop_data.seed || travelled_reg != '0 || out_free);
    assign do_pop    = pop_valid && pop_ready;
    assign emit      = do_pop && !pop_data.seed && travelled_reg == '0;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    always_comb begin
        state_next     = state_reg;
        travelled_next = travelled_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !m_ready;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        xhh_next       = xhh_reg;
        xhl_next       = xhl_reg;
        xll_next       = xll_reg;
        yhh_next       = yhh_reg;
        yhl_next       = yhl_reg;
        yll_next       = yll_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        rad_next       = rad_reg;
        sq_next        = sq_reg;
        step_next      = step_reg;
        sq_mid         = wald_pkg::sqrt_step(sq_reg, rad_reg[wald_pkg::RAD_W-1 -: 2]);
        sum            = {1'b0, travelled_reg} + {1'b0, sq_reg.root};
        sat            = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

        if (emit) begin
            out_item_next  = pop_data.item;
            out_valid_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (do_pop) begin
                    if (pop_data.seed) begin
                        travelled_next = '0;
                    end else begin
                        ax_next    = pop_data.ax;
                        ay_next    = pop_data.ay;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                // 12x12 partial products of each square
                xhh_next   = {{HW{1'b0}}, ax_reg[PW-1:HW]} * {{HW{1'b0}}, ax_reg[PW-1:HW]};
                xhl_next   = {{HW{1'b0}}, ax_reg[PW-1:HW]} * {{HW{1'b0}}, ax_reg[HW-1:0]};
                xll_next   = {{HW{1'b0}}, ax_reg[HW-1:0]}  * {{HW{1'b0}}, ax_reg[HW-1:0]};
                yhh_next   = {{HW{1'b0}}, ay_reg[PW-1:HW]} * {{HW{1'b0}}, ay_reg[PW-1:HW]};
                yhl_next   = {{HW{1'b0}}, ay_reg[PW-1:HW]} * {{HW{1'b0}}, ay_reg[HW-1:0]};
                yll_next   = {{HW{1'b0}}, ay_reg[HW-1:0]}  * {{HW{1'b0}}, ay_reg[HW-1:0]};
                state_next = ST_SUM;
            end
            ST_SUM: begin
                sqx_next   = {xhh_reg, {PW{1'b0}}} + {{(HW-1){1'b0}}, xhl_reg, {(HW+1){1'b0}}}
                           + {{PW{1'b0}}, xll_reg};
                sqy_next   = {yhh_reg, {PW{1'b0}}} + {{(HW-1){1'b0}}, yhl_reg, {(HW+1){1'b0}}}
                           + {{PW{1'b0}}, yll_reg};
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                rad_next   = {4'b0, sqx_reg} + {4'b0, sqy_reg};
                sq_next    = '0;
                step_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                sq_next   = wald_pkg::sqrt_step(sq_mid, rad_reg[wald_pkg::RAD_W-3 -: 2]);
                rad_next  = {rad_reg[wald_pkg::RAD_W-5:0], 4'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                travelled_next = (sat >= {{(TW-wald_pkg::SPACING_W){1'b0}}, spacing}) ? '0 : sat;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            travelled_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            travelled_reg <= travelled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_item_reg <= out_item_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        xhh_reg      <= xhh_next;
        xhl_reg      <= xhl_next;
        xll_reg      <= xll_next;
        yhh_reg      <= yhh_next;
        yhl_reg      <= yhl_next;
        yll_reg      <= yll_next;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        rad_reg      <= rad_next;
        sq_reg       <= sq_next;
        step_reg     <= step_next;
    end

endmodule

// ===== src/waypoint_arc_length_decimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_arc_length_decimator_top
// Thins a stream of trajectory points by travelled distance.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item   one trajectory point per transfer. The first
//                            point of a path (or the first after reset)
//                            only seeds the previous position.
//   m_valid/m_ready/m_item   kept waypoints, zero or one per point.
//   cfg_valid/cfg_ready/cfg_spacing  spacing in unsigned Q16.8 m; ready is
//                            always high. Write only while the block is idle.
// Path: with the back end idle, a kept point is registered in a queue entry,
//   then in the output register that drives m_valid.
// Back end: a seed point takes only the pop; any other point takes in turn
//   the pop, squares, square sums, radicand, the two-bit-per-cycle square
//   root, then the accumulate; no new point is popped until it is done.
//   The root is the loop that sets the rate.
// The front end and a QUEUE_DEPTH-entry queue keep taking points while the
//   back end works, so s_ready only drops when the queue is full.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
//   result, clears the accumulator and the seeded flag, spacing -> 5.0 m.
// A stalled receiver holds m_item; the back end then waits only on points
//   that must be emitted, and the queue fills behind it.
// ----------------------------------------------------------------------------
module waypoint_arc_length_decimator_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  wald_pkg::in_item_t              s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output wald_pkg::out_item_t             m_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wald_pkg::SPACING_W-1:0]  cfg_spacing
);

    // Spacing register, written through its own channel
    logic [wald_pkg::SPACING_W-1:0] spacing_reg, spacing_next;

    // Front -> queue
    logic                   push_valid, push_ready;
    wald_pkg::queue_entry_t push_data;

    // Queue -> back
    logic                   pop_valid, pop_ready;
    wald_pkg::queue_entry_t pop_data;

    assign cfg_ready    = 1'b1;
    assign spacing_next = (cfg_valid && cfg_ready) ? cfg_spacing : spacing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= wald_pkg::SPACING_RESET;
        end else begin
            spacing_reg <= spacing_next;
        end
    end

    // Classifies points and forms the coordinate differences
    wald_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouples the front from the multi-cycle distance unit
    wald_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Emission decision, step length and accumulator
    wald_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .spacing   (spacing_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// ===== src/wald_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wald_checker
// Port-level checks for the decimator, bound to the top level.
// ----------------------------------------------------------------------------
module wald_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input wald_pkg::in_item_t              s_item,
    input logic                            m_valid,
    input logic                            m_ready,
    input wald_pkg::out_item_t             m_item
);

    // Points that may still yield a result: non-seed points in minus results out.
    logic [15:0] credit_reg, credit_next;
    logic        seeded_reg, seeded_next;
    logic        in_xfer, out_xfer, earns;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;
    assign earns    = in_xfer && seeded_reg && !s_item.start_of_path;

    always_comb begin
        seeded_next = seeded_reg || in_xfer;
        credit_next = credit_reg;
        if (credit_reg != '1) begin
            credit_next = credit_reg + {15'b0, earns} - {15'b0, out_xfer};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
            seeded_reg <= 1'b0;
        end else begin
            credit_reg <= credit_next;
            seeded_reg <= seeded_next;
        end
    end

    a_reset_no_result: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed or dropped");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer |-> credit_reg != '0)
        else $error("result without a preceding non-seed point");

endmodule

bind waypoint_arc_length_decimator_top wald_checker u_wald_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_item      (s_item),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_item      (m_item)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives trajectory points into the arc-length decimator and checks each
// kept waypoint against a cycle-free predictor of the decimation rule.
// Runs a short directed path at the reset spacing, then random paths over
// several spacing settings, with random idling on both sides and one long
// receiver stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [wald_pkg::SPACING_W-1:0] SPACING_MIN = 24'd1;
    localparam logic [wald_pkg::SPACING_W-1:0] SPACING_MAX = 24'hFFFFFF;
    localparam logic [wald_pkg::TRAVEL_W-1:0]  TRAVEL_SAT  = {wald_pkg::TRAVEL_W{1'b1}};
    localparam int DRAIN_PAD   = 80;      // back end margin, queue of 2
    localparam int HOLD_AT     = 60;      // points taken before the long stall
    localparam int HOLD_LEN    = 300;     // receiver stall, cycles
    localparam int REPORT_MAX  = 10;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input known from time zero
    // ------------------------------------------------------------------
    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    wald_pkg::in_item_t             s_item      = '0;
    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    wald_pkg::out_item_t            m_item;
    logic                           cfg_valid   = 1'b0;
    logic                           cfg_ready;
    logic [wald_pkg::SPACING_W-1:0] cfg_spacing = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    waypoint_arc_length_decimator_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_spacing (cfg_spacing)
    );

    // ------------------------------------------------------------------
    // Bookkeeping shared between the processes
    // ------------------------------------------------------------------
    wald_pkg::in_item_t  point_q[$];        // points waiting to be driven
    wald_pkg::out_item_t kept_q[$];         // waypoints the block still owes us
    int        points_sent  = 0;  // pushed into point_q
    int        points_taken = 0;  // accepted by the block
    int        cfg_writes   = 0;
    int        mismatches   = 0;
    logic      s_taken      = 1'b0;  // transfer on s_ at the last rising edge
    logic      quiet;                // no idling on either side

    assign quiet = (points_taken >= 400) && (points_taken < 520);

    // ------------------------------------------------------------------
    // Predictor state: own copy of spacing and the path tracker
    // ------------------------------------------------------------------
    logic [wald_pkg::SPACING_W-1:0]      spacing_now = wald_pkg::SPACING_RESET;
    logic signed [wald_pkg::COORD_W-1:0] last_x      = '0;
    logic signed [wald_pkg::COORD_W-1:0] last_y      = '0;
    logic [wald_pkg::TRAVEL_W-1:0]       travelled   = '0;
    logic                                seeded      = 1'b0;

    // floor(sqrt(n)) for n < 2^52, one root bit at a time from the top
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 25; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // Applies one accepted point to the tracker and queues the waypoint it keeps
    function automatic void advance_path(input wald_pkg::in_item_t p);
        longint              dx;
        longint              dy;
        longint unsigned     ax;
        longint unsigned     ay;
        longint unsigned     sum;
        wald_pkg::out_item_t k;
        // new trajectory, or a stray point before any seed: seed only
        if (p.start_of_path || !seeded) begin
            last_x    = p.x_position;
            last_y    = p.y_position;
            travelled = '0;
            seeded    = 1'b1;
            return;
        end
        if (travelled == '0) begin
            k.kept_x             = p.x_position;
            k.kept_y             = p.y_position;
            k.kept_heading       = p.heading;
            k.kept_speed         = p.speed;
            k.kept_acceleration  = p.acceleration;
            k.kept_speed_command = p.speed_command;
            k.kept_steer_command = p.steer_command;
            kept_q = {kept_q, k};
        end
        dx  = longint'(p.x_position) - longint'(last_x);
        dy  = longint'(p.y_position) - longint'(last_y);
        ax  = (dx < 0) ? -dx : dx;
        ay  = (dy < 0) ? -dy : dy;
        sum = longint'(travelled) + floor_sqrt(ax * ax + ay * ay);
        if (sum > longint'(TRAVEL_SAT))
            sum = 64'(TRAVEL_SAT);
        travelled = sum[wald_pkg::TRAVEL_W-1:0];
        if (travelled >= {2'b00, spacing_now})
            travelled = '0;
        last_x = p.x_position;
        last_y = p.y_position;
    endfunction

    function automatic logic same_waypoint(input wald_pkg::out_item_t a,
                                           input wald_pkg::out_item_t b);
        return a.kept_x === b.kept_x && a.kept_y === b.kept_y
            && a.kept_heading === b.kept_heading && a.kept_speed === b.kept_speed
            && a.kept_acceleration === b.kept_acceleration
            && a.kept_speed_command === b.kept_speed_command
            && a.kept_steer_command === b.kept_steer_command;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge, before the DUT's
    // own updates land. Point transfers feed the predictor, result
    // transfers are checked against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        wald_pkg::out_item_t want;
        s_taken = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                spacing_now = cfg_spacing;
                cfg_writes++;
            end
            if (s_valid && s_ready) begin
                s_taken = 1'b1;
                advance_path(s_item);
                points_taken++;
            end
            if (m_valid && m_ready) begin
                if (kept_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected waypoint %h", $realtime, m_item);
                end else begin
                    want = kept_q.pop_front();
                    if (!same_waypoint(want, m_item)) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: waypoint mismatch, expected %h, got %h",
                                     $realtime, want, m_item);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: falling edge. Holds a point until its transfer, otherwise
    // offers the next one unless it rolls an idle cycle.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !s_taken) begin
                s_valid <= 1'b1;
            end else if (point_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
                s_item  <= point_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long stall while the
    // sender keeps offering, so the internal queue fills and s_ready drops.
    // ------------------------------------------------------------------
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!hold_done && points_taken >= HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_point(input logic start, input logic [23:0] x, input logic [23:0] y,
                             input logic [15:0] pass);
        wald_pkg::in_item_t p;
        p.start_of_path = start;
        p.x_position    = x;
        p.y_position    = y;
        p.heading       = pass;
        p.speed         = pass;
        p.acceleration  = pass;
        p.speed_command = pass;
        p.steer_command = pass;
        point_q = {point_q, p};
        points_sent++;
    endtask

    // Random trajectories: a seed, then steps of up to step_max LSBs per axis.
    // step_max of 0 means every coordinate is drawn at random. Some noise:
    // teleports, stray path starts, paths with no start flag, standing still.
    task automatic queue_paths(input int n_points, input int step_max);
        int                 left;
        int                 len;
        int                 dx;
        int                 dy;
        logic [23:0]        x;
        logic [23:0]        y;
        wald_pkg::in_item_t p;
        left = n_points;
        while (left > 0) begin
            len = $urandom_range(2, 24);
            if (len > left)
                len = left;
            x = 24'($urandom);
            y = 24'($urandom);
            for (int i = 0; i < len; i++) begin
                if (step_max == 0 || $urandom_range(0, 19) == 0) begin
                    x = 24'($urandom);
                    y = 24'($urandom);
                end else if (i > 0 && $urandom_range(0, 9) != 0) begin
                    dx = int'($urandom_range(0, 2 * step_max)) - step_max;
                    dy = int'($urandom_range(0, 2 * step_max)) - step_max;
                    x  = x + dx[23:0];
                    y  = y + dy[23:0];
                end
                p.start_of_path = (i == 0) ? ($urandom_range(0, 19) != 0)
                                           : ($urandom_range(0, 49) == 0);
                p.x_position    = x;
                p.y_position    = y;
                p.heading       = 16'($urandom);
                p.speed         = 16'($urandom);
                p.acceleration  = 16'($urandom);
                p.speed_command = 16'($urandom);
                p.steer_command = 16'($urandom);
                point_q = {point_q, p};
                points_sent++;
            end
            left -= len;
        end
    endtask

    // Waits until every point is in and every waypoint out, then lets the
    // back end finish any point that keeps nothing.
    task automatic drain;
        while (points_taken != points_sent || kept_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_PAD) @(negedge aclk);
    endtask

    task automatic write_spacing(input logic [wald_pkg::SPACING_W-1:0] value);
        int seen;
        seen = cfg_writes;
        @(negedge aclk);
        cfg_spacing <= value;
        cfg_valid   <= 1'b1;
        while (cfg_writes == seen)
            @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed path at the reset spacing (5.0 m = 1280 LSB)
        add_point(1'b0, 24'h7FFFFF, 24'h800000, 16'h1234);  // no seed yet: seeds
        add_point(1'b0, 24'h800000, 24'h7FFFFF, 16'h8000);  // kept, full-range step
        add_point(1'b0, 24'h800000, 24'h7FFFFF, 16'h7FFF);  // zero step: kept
        add_point(1'b0, 24'h800000, 24'h7FFFFF, 16'hFFFF);  // and kept again
        add_point(1'b1, 24'd0,      24'd0,      16'h0000);  // new path
        add_point(1'b0, 24'd300,    24'd0,      16'h0001);  // kept, 300 travelled
        add_point(1'b0, 24'd600,    24'd0,      16'h0002);
        add_point(1'b0, 24'd900,    24'd0,      16'h0003);
        add_point(1'b0, 24'd1200,   24'd0,      16'h0004);
        add_point(1'b0, 24'd1500,   24'd0,      16'h0005);  // reaches spacing: clear
        add_point(1'b0, 24'd1800,   24'd0,      16'h0006);  // kept
        add_point(1'b0, 24'd2568,   24'd1024,   16'h0007);  // 3-4-5 step of exactly 1280
        add_point(1'b0, 24'd2668,   24'd1024,   16'h0008);  // kept, 100 travelled
        add_point(1'b1, -24'd5000,  -24'd5000,  16'hAAAA);  // restart mid-path
        add_point(1'b0, -24'd5001,  -24'd5000,  16'h5555);  // kept after restart
        add_point(1'b0, -24'd5001,  -24'd3000,  16'hFFFE);
        add_point(1'b0, -24'd5001,  -24'd2999,  16'h8001);  // kept
        drain();

        // Every non-first point kept; the long receiver stall lands here
        write_spacing(SPACING_MIN);
        queue_paths(150, 2000);
        drain();

        // Largest spacing with teleporting points
        write_spacing(SPACING_MAX);
        queue_paths(120, 0);
        drain();

        write_spacing(24'($urandom_range(256, 4096)));
        queue_paths(150, 600);
        drain();

        write_spacing(24'($urandom_range(1, 24'hFFFFFF)));
        queue_paths(120, 0);
        drain();

        write_spacing(wald_pkg::SPACING_RESET);
        queue_paths(160, 300);
        drain();

        // Tiny spacing with tiny steps: lots of zero-length moves
        write_spacing(24'd2);
        queue_paths(150, 4);
        drain();

        if (mismatches == 0 && kept_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== waypoint_arc_length_decimator_top.f =====
src/wald_pkg.sv
src/wald_front.sv
src/wald_queue.sv
src/wald_back.sv
src/waypoint_arc_length_decimator_top.sv
src/wald_checker.sv
dv/testbench.sv
